// ===== rtl/skf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned GainW = 17;
  localparam int unsigned FracW = 16;
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned CntW = 5;
  localparam int unsigned MulOpW = 18;
  localparam int unsigned ProdW = 2 * MulOpW;
  localparam int unsigned AccW = 51;

  localparam logic [DataW-1:0] QReset = 32'd1311;
  localparam logic [DataW-1:0] RReset = 32'd458752;

  typedef enum logic {
    REG_PROCESS_NOISE = 1'b0,
    REG_MEASURE_NOISE = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PREP = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/scalar_kalman_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional fixed-point Kalman filter.
// Input channel: measurement_i (signed Q16.16) with in_valid_i / in_ready_o.
// Output channel: estimate_o (signed Q16.16) and gain_o (unsigned Q1.16)
// with out_valid_o / out_ready_i; one output word per input word.
// Config: cfg_we_i writes cfg_wdata_i to Q (index 0) or R (index 1) at once.
// Each word runs through a small sequencer: a setup state, a restoring
// division for the 17-bit gain (one quotient bit per cycle), then the
// products on one shared 18x18 multiplier for the estimate and covariance
// updates, and a final state that loads the output register. A new word
// is taken in the cycle after the previous one finishes, so the filter
// cannot accept a word before it is through with the last one.
// in_ready_o is high only while the sequencer is idle. The output register
// holds a finished word until taken; if it is still full when the next
// word finishes, the sequencer waits and stays not ready.
// Reset clears the estimate and covariance to zero and loads Q = 1311
// (about 0.02) and R = 458752 (7.0).

module scalar_kalman_filter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_addr_i,
  input  wire [skf_pkg::DataW-1:0]         cfg_wdata_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire signed [skf_pkg::DataW-1:0]  measurement_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic signed [skf_pkg::DataW-1:0] estimate_o,
  output logic [skf_pkg::GainW-1:0]        gain_o
);

  skf_pkg::state_e state_q, state_d;
  logic [skf_pkg::CntW-1:0] cnt_q, cnt_d;

  logic [skf_pkg::DataW-1:0] q_noise_q, r_noise_q;
  logic [skf_pkg::DataW-1:0] est_q, est_d;
  logic [skf_pkg::DataW-1:0] cov_q, cov_d;

  logic [skf_pkg::DataW-1:0] meas_q;
  logic [skf_pkg::DataW-1:0] p_q, p_d;
  logic [skf_pkg::DataW:0]   den_q, den_d;
  logic [skf_pkg::DataW:0]   innov_q, innov_d;
  logic [skf_pkg::DataW+1:0] rem_q, rem_d;
  logic [skf_pkg::GainW-1:0] g_q, g_d;

  logic signed [skf_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [skf_pkg::AccW-1:0]  acc_q, acc_d;

  logic                     out_valid_q, out_valid_d;
  logic [skf_pkg::DataW-1:0] out_est_q, out_est_d;
  logic [skf_pkg::GainW-1:0] out_gain_q, out_gain_d;

  logic [skf_pkg::DataW:0]   p_sum;
  logic [skf_pkg::DataW-1:0] p_sat;
  logic [skf_pkg::DataW+1:0] rem_cmp;
  logic [skf_pkg::DataW+1:0] rem_sub;
  logic                      qbit;
  logic [skf_pkg::GainW-1:0] gm;
  logic signed [skf_pkg::MulOpW-1:0] mul_a, mul_b;
  logic signed [skf_pkg::AccW-1:0]   prod_ext, term;
  logic [1:0] acc_step;

  assign in_ready_o  = (state_q == skf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign estimate_o  = out_est_q;
  assign gain_o      = out_gain_q;

  assign p_sum = {1'b0, cov_q} + {1'b0, q_noise_q};
  assign p_sat = p_sum[skf_pkg::DataW] ? '1 : p_sum[skf_pkg::DataW-1:0];

  assign rem_cmp = (cnt_q == '0) ? rem_q : {rem_q[skf_pkg::DataW:0], 1'b0};
  assign rem_sub = rem_cmp - {1'b0, den_q};
  assign qbit    = (rem_cmp >= {1'b0, den_q});

  assign gm = skf_pkg::GainW'(18'd65536 - {1'b0, g_q});

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: begin
        mul_a = {1'b0, g_q};
        mul_b = {2'b00, innov_q[skf_pkg::FracW-1:0]};
      end
      2'd1: begin
        mul_a = {1'b0, g_q};
        mul_b = {innov_q[skf_pkg::DataW], innov_q[skf_pkg::DataW:skf_pkg::FracW]};
      end
      2'd2: begin
        mul_a = {1'b0, gm};
        mul_b = {2'b00, p_q[skf_pkg::FracW-1:0]};
      end
      default: begin
        mul_a = {1'b0, gm};
        mul_b = {2'b00, p_q[skf_pkg::DataW-1:skf_pkg::FracW]};
      end
    endcase
  end

  assign acc_step = 2'(cnt_q - 5'd1);
  assign prod_ext = {{(skf_pkg::AccW - skf_pkg::ProdW){prod_q[skf_pkg::ProdW-1]}}, prod_q};
  assign term     = acc_step[0] ? (prod_ext <<< skf_pkg::FracW) : prod_ext;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    est_d       = est_q;
    cov_d       = cov_q;
    p_d         = p_q;
    den_d       = den_q;
    innov_d     = innov_q;
    rem_d       = rem_q;
    g_d         = g_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    out_est_d   = out_est_q;
    out_gain_d  = out_gain_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      skf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = skf_pkg::ST_PREP;
        end
      end
      skf_pkg::ST_PREP: begin
        p_d     = p_sat;
        den_d   = {1'b0, p_sat} + {1'b0, r_noise_q};
        innov_d = {meas_q[skf_pkg::DataW-1], meas_q} - {est_q[skf_pkg::DataW-1], est_q};
        rem_d   = {2'b00, p_sat};
        g_d     = '0;
        cnt_d   = '0;
        state_d = skf_pkg::ST_DIV;
      end
      skf_pkg::ST_DIV: begin
        rem_d = qbit ? rem_sub : rem_cmp;
        g_d   = {g_q[skf_pkg::GainW-2:0], qbit};
        if (cnt_q == skf_pkg::CntW'(skf_pkg::DivSteps - 1)) begin
          if (den_q == '0) begin
            g_d = '0;
          end
          cnt_d   = '0;
          state_d = skf_pkg::ST_MUL;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      skf_pkg::ST_MUL: begin
        if (cnt_q < 5'd4) begin
          prod_d = mul_a * mul_b;
        end
        if (cnt_q != '0) begin
          acc_d = acc_step[0] ? (acc_q + term) : term;
        end
        if (cnt_q == 5'd3) begin
          est_d = est_q + acc_q[skf_pkg::FracW+skf_pkg::DataW-1:skf_pkg::FracW];
        end
        if (cnt_q == 5'd4) begin
          state_d = skf_pkg::ST_FIN;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      skf_pkg::ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cov_d       = acc_q[skf_pkg::FracW+skf_pkg::DataW-1:skf_pkg::FracW];
          out_valid_d = 1'b1;
          out_est_d   = est_q;
          out_gain_d  = g_q;
          state_d     = skf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skf_pkg::ST_IDLE;
      cnt_q       <= '0;
      est_q       <= '0;
      cov_q       <= '0;
      q_noise_q   <= skf_pkg::QReset;
      r_noise_q   <= skf_pkg::RReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      est_q       <= est_d;
      cov_q       <= cov_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (skf_pkg::reg_idx_e'(cfg_addr_i))
          skf_pkg::REG_PROCESS_NOISE: q_noise_q <= cfg_wdata_i;
          skf_pkg::REG_MEASURE_NOISE: r_noise_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      meas_q <= measurement_i;
    end
    p_q        <= p_d;
    den_q      <= den_d;
    innov_q    <= innov_d;
    rem_q      <= rem_d;
    g_q        <= g_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_est_q  <= out_est_d;
    out_gain_q <= out_gain_d;
  end

endmodule

`default_nettype wire

// ===== tb/kalman_checker.sv =====
`timescale 1ns / 1ps

module kalman_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_addr_i,
  input  logic [skf_pkg::DataW-1:0]        cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic signed [skf_pkg::DataW-1:0] measurement_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic signed [skf_pkg::DataW-1:0] estimate_i,
  input  logic [skf_pkg::GainW-1:0]        gain_i,
  output int                               mismatches_o,
  output int                               pending_o,
  output int                               taken_o,
  output int                               checked_o,
  output int                               saturated_o,
  output int                               unity_o,
  output int                               zero_den_o
);

  typedef struct packed {
    logic signed [skf_pkg::DataW-1:0] estimate;
    logic [skf_pkg::GainW-1:0]        gain;
  } filter_out_t;

  logic [skf_pkg::DataW-1:0]        q_noise;
  logic [skf_pkg::DataW-1:0]        r_noise;
  logic signed [skf_pkg::DataW-1:0] est;
  logic [skf_pkg::DataW-1:0]        cov;
  filter_out_t                      expected_updates[$];
  filter_out_t                      want;
  int n_mismatch, n_taken, n_checked, n_saturated, n_unity, n_zero_den;

  task automatic report_mismatch(input string msg);
    n_mismatch++;
    $display("%0t ns: mismatch, %s", $time, msg);
  endtask

  function automatic filter_out_t kalman_update(
    input logic signed [skf_pkg::DataW-1:0] meas
  );
    logic [skf_pkg::DataW:0]   p_sum;
    logic [skf_pkg::DataW-1:0] p;
    logic [skf_pkg::DataW:0]   den;
    logic [63:0]               gq;
    logic [skf_pkg::GainW-1:0] g;
    longint                    innov;
    longint                    delta;
    logic [63:0]               cov_next;
    filter_out_t               res;
    p_sum = {1'b0, cov} + {1'b0, q_noise};
    p = p_sum[skf_pkg::DataW] ? '1 : p_sum[skf_pkg::DataW-1:0];
    den = {1'b0, p} + {1'b0, r_noise};
    if (den == '0) gq = '0;
    else gq = {16'b0, p, 16'b0} / {31'b0, den};
    if (gq > 64'd65536) gq = 64'd65536;
    g = gq[skf_pkg::GainW-1:0];
    innov = longint'(meas) - longint'(est);
    delta = (longint'({47'b0, g}) * innov) >>> skf_pkg::FracW;
    est = est + delta[skf_pkg::DataW-1:0];
    cov_next = ({32'b0, p} * (64'd65536 - {47'b0, g})) >> skf_pkg::FracW;
    cov = cov_next[skf_pkg::DataW-1:0];
    if (p_sum[skf_pkg::DataW]) n_saturated++;
    if (g == 17'd65536) n_unity++;
    if (den == '0) n_zero_den++;
    res.estimate = est;
    res.gain = g;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise = skf_pkg::QReset;
      r_noise = skf_pkg::RReset;
      est = '0;
      cov = '0;
      expected_updates.delete();
      n_mismatch = 0;
      n_taken = 0;
      n_checked = 0;
      n_saturated = 0;
      n_unity = 0;
      n_zero_den = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      taken_o <= 0;
      checked_o <= 0;
      saturated_o <= 0;
      unity_o <= 0;
      zero_den_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == skf_pkg::REG_PROCESS_NOISE) q_noise = cfg_wdata_i;
        else r_noise = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        expected_updates.push_back(kalman_update(measurement_i));
        n_taken++;
      end
      if (out_valid_i && out_ready_i) begin
        n_checked++;
        if (expected_updates.size() == 0) begin
          report_mismatch($sformatf("output word with none expected (estimate %0d, gain %0d)",
                                    estimate_i, gain_i));
        end else begin
          want = expected_updates.pop_front();
          if (estimate_i !== want.estimate)
            report_mismatch($sformatf("word %0d estimate: expected %0d, got %0d",
                                      n_checked, want.estimate, estimate_i));
          if (gain_i !== want.gain)
            report_mismatch($sformatf("word %0d gain: expected %0d, got %0d",
                                      n_checked, want.gain, gain_i));
        end
      end
      mismatches_o <= n_mismatch;
      pending_o <= expected_updates.size();
      taken_o <= n_taken;
      checked_o <= n_checked;
      saturated_o <= n_saturated;
      unity_o <= n_unity;
      zero_den_o <= n_zero_den;
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int CycleLimit = 500000;
  localparam int HoldOff = 300;
  localparam int RandomWords = 650;
  localparam int NoiseAmp = 262144;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_addr_i;
  logic [skf_pkg::DataW-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  logic [skf_pkg::DataW-1:0] measurement_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [skf_pkg::DataW-1:0] estimate_o;
  logic [skf_pkg::GainW-1:0] gain_o;

  int mismatches, pending, taken, checked, saturated, unity, zero_den;
  int cycle_count = 0;
  int burst_left = 0;
  int settings = 1;

  scalar_kalman_filter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .measurement_i(measurement_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .estimate_o   (estimate_o),
    .gain_o       (gain_o)
  );

  kalman_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .measurement_i(measurement_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .estimate_i   (estimate_o),
    .gain_i       (gain_o),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .taken_o      (taken),
    .checked_o    (checked),
    .saturated_o  (saturated),
    .unity_o      (unity),
    .zero_den_o   (zero_den)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycle_count, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sink side: stall patterns that change every segment, plus one long hold-off
  initial begin
    int mode;
    int seg;
    int tick;
    bit held;
    out_ready_i = 1'b0;
    held = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg = $urandom_range(20, 200);
      repeat (seg) begin
        @(posedge clk_i);
        tick++;
        if (!held && taken >= 48) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HoldOff) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(0, 1);
          2: out_ready_i <= (tick % 5) < 3;
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_measurement(input logic [skf_pkg::DataW-1:0] value);
    int gap;
    in_valid_i <= 1'b1;
    measurement_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        measurement_i <= $urandom;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // only called with the filter idle
  task automatic load_noise(input logic [skf_pkg::DataW-1:0] q,
                            input logic [skf_pkg::DataW-1:0] r);
    drain();
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= skf_pkg::REG_PROCESS_NOISE;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_addr_i <= skf_pkg::REG_MEASURE_NOISE;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [skf_pkg::DataW-1:0] corners[4];
    int sent;
    int phase_len;
    int target;
    int kind;
    logic [skf_pkg::DataW-1:0] meas;
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = skf_pkg::REG_PROCESS_NOISE;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    measurement_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset noise values, full-scale swings
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h0000_0000);
    send_measurement(32'hFFFF_FFFF);
    send_measurement(32'h0000_0001);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    // Q = R = 0: unity gain clears covariance, then zero denominator
    load_noise('0, '0);
    send_measurement(32'h1234_5678);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    // covariance saturation
    load_noise('1, '1);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    load_noise('1, '0);
    send_measurement(32'h8000_0000);
    send_measurement(32'h7FFF_FFFF);
    load_noise('0, '1);
    send_measurement(32'h0000_0000);
    send_measurement(32'hFFFF_FFFF);

    sent = 0;
    target = $urandom;
    while (sent < RandomWords) begin
      if (sent > 0) begin
        kind = $urandom_range(0, 5);
        case (kind)
          0: load_noise($urandom_range(0, 32'h0002_0000), $urandom_range(1, 32'h0100_0000));
          1: load_noise($urandom, $urandom);
          2: load_noise('0, $urandom);
          3: load_noise($urandom, '0);
          4: load_noise('1, $urandom);
          default: load_noise($urandom_range(0, 32'h0001_0000), '1);
        endcase
      end
      phase_len = $urandom_range(60, 100);
      while (phase_len > 0 && sent < RandomWords) begin
        kind = $urandom_range(0, 7);
        target += int'($urandom_range(0, 2000)) - 1000;
        if (kind < 4) begin
          meas = target + int'($urandom_range(0, 2 * NoiseAmp)) - NoiseAmp;
        end else if (kind < 6) begin
          meas = $urandom;
        end else if (kind == 6) begin
          meas = corners[$urandom_range(0, 3)];
        end else begin
          target = $urandom;
          meas = target;
        end
        send_measurement(meas);
        sent++;
        phase_len--;
      end
    end

    drain();
    repeat (30) @(posedge clk_i);
    $display("Filtered %0d measurements, checked %0d output words, %0d noise settings.",
             taken, checked, settings);
    $display("Steps with saturated covariance %0d, unity gain %0d, zero denominator %0d.",
             saturated, unity, zero_den);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== scalar_kalman_filter.f =====
rtl/skf_pkg.sv
rtl/scalar_kalman_filter.sv
tb/kalman_checker.sv
tb/tb.sv
